### hdl/srms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srms_pkg: shared types and constants of the score rank merge sorter
// Chain record layout, cell and location-table controls, action codes.
// ----------------------------------------------------------------------------
package srms_pkg;

  localparam int CAPACITY  = 64;
  localparam int LOCATIONS = 128;

  localparam int ID_W    = 44;
  localparam int SCORE_W = 16;
  localparam int LOCIN_W = 8;
  localparam int RANK_W  = 7;
  localparam int LOC_W   = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;

  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_e;

  typedef struct packed {
    logic [ID_W-1:0]    reg_id;
    logic [SCORE_W-1:0] score;
    logic [LOC_W-1:0]   loc;
  } dat_t;

  typedef struct packed {
    logic valid;
    dat_t dat;
  } rec_t;

  typedef struct packed {
    logic insert;
    logic pop;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic             rd;
    logic             commit;
    logic             clear;
    logic [LOC_W-1:0] addr;
  } loc_req_t;

  typedef struct packed {
    logic [RANK_W-1:0]  seen;
    logic [SCORE_W-1:0] score;
    logic [RANK_W-1:0]  rank;
  } loc_ent_t;

  // Saturating increment of a rank-wide counter
  function automatic logic [RANK_W-1:0] sat_inc(input logic [RANK_W-1:0] v);
    sat_inc = (v == RANK_MAX) ? v : v + RANK_W'(1);
  endfunction

endpackage
`default_nettype wire

### hdl/srms_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srms_cell: one cell of the sorted chain
// Holds one record; compares it against the broadcast key on insert and
// takes key or left neighbor, shifts from the right on pop, empties on clear.
// ----------------------------------------------------------------------------
module srms_cell
  import srms_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire rec_t       key_i,
  input  wire rec_t       left_i,
  input  wire logic       left_keep_i,
  input  wire rec_t       right_i,
  output      rec_t       rec_o,
  output      logic       keep_o
);

  logic vld_q, vld_d;
  dat_t dat_q, dat_d;

  // Stay in place when the held record sorts at or before the key
  assign keep_o = vld_q &&
                  ((dat_q.score > key_i.dat.score) ||
                   ((dat_q.score == key_i.dat.score) && (dat_q.reg_id <= key_i.dat.reg_id)));

  assign rec_o = '{valid: vld_q, dat: dat_q};

  always_comb begin
    vld_d = vld_q;
    dat_d = dat_q;
    if (ctrl_i.clear) begin
      vld_d = 1'b0;
    end else if (ctrl_i.insert && !keep_o) begin
      if (left_keep_i) begin
        vld_d = key_i.valid;
        dat_d = key_i.dat;
      end else begin
        vld_d = left_i.valid;
        dat_d = left_i.dat;
      end
    end else if (ctrl_i.pop) begin
      vld_d = right_i.valid;
      dat_d = right_i.dat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dat_q <= dat_d;
  end

endmodule
`default_nettype wire

### hdl/srms_loc_rank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srms_loc_rank: per-location running count, last score and last rank
// Table entry read on pop; local rank formed from it, written back on commit.
// ----------------------------------------------------------------------------
module srms_loc_rank
  import srms_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire loc_req_t           req_i,
  input  wire logic [SCORE_W-1:0] score_i,
  output      logic [RANK_W-1:0]  lrank_o
);

  loc_ent_t               mem [LOCATIONS];
  logic [LOCATIONS-1:0]   vld_q;
  loc_ent_t               rd_q;
  logic                   hit_q;
  logic [LOC_W-1:0]       addr_q;
  logic [RANK_W-1:0]      seen_old, seen_new;

  assign seen_old = hit_q ? rd_q.seen : '0;
  assign seen_new = sat_inc(seen_old);
  // First pop of the location, or a new score: rank is the running count
  assign lrank_o  = ((seen_old == '0) || (score_i != rd_q.score)) ? seen_new : rd_q.rank;

  always_ff @(posedge clk_i) begin
    if (req_i.rd) begin
      rd_q   <= mem[req_i.addr];
      addr_q <= req_i.addr;
    end
    if (req_i.commit) begin
      mem[addr_q] <= '{seen: seen_new, score: score_i, rank: lrank_o};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (req_i.rd) begin
        hit_q <= vld_q[req_i.addr];
      end
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.commit) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/score_rank_merge_sorter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// score_rank_merge_sorter: sorted record chain with competition ranking
// Loads records into a chain kept in score-descending, id-ascending order;
// pops the head with its overall and per-location competition rank.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per action:
//   insert, pop, clear or no operation. Output channel (out_valid_o /
//   out_stall_i) carries one word per pop, nothing for other actions.
//   Inserts stream in back to back, every cell of the chain comparing
//   against the new key in the same cycle. A pop has two steps: on
//   acceptance it reads the head cell and the location table; in ST_POP
//   it forms the local rank, writes the table back and loads the output
//   register. in_stall_o is high in ST_POP; the table's single read and
//   write port calls for this. When the receiver stalls, the result
//   holds in the output register; inserts and clears are still taken,
//   and a following pop waits in ST_POP until the register frees up.
//   Reset empties the chain and zeroes all counters and location counts;
//   no clearing pass is needed, the block takes words right after reset.
//   An insert into a full chain is dropped and raises overflow for the
//   batch; an insert with an out-of-range location is dropped silently.
// ----------------------------------------------------------------------------
module score_rank_merge_sorter
  import srms_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [1:0]         action_i,
  input  wire logic [ID_W-1:0]    reg_id_i,
  input  wire logic [SCORE_W-1:0] score_i,
  input  wire logic [LOCIN_W-1:0] location_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [ID_W-1:0]    out_reg_id_o,
  output      logic [RANK_W-1:0]  overall_rank_o,
  output      logic [LOCIN_W-1:0] out_location_o,
  output      logic [RANK_W-1:0]  loc_rank_o,
  output      logic [RANK_W-1:0]  total_count_o,
  output      logic               empty_res_o,
  output      logic               overflow_o
);

  localparam int CMP_W = (LOC_W > LOCIN_W) ? LOC_W + 1 : LOCIN_W + 1;

  state_e state_q, state_d;

  // Chain wiring
  rec_t                chain [CAPACITY];
  logic [CAPACITY-1:0] keep;
  logic [CAPACITY-1:0] chain_vld;
  rec_t                key;
  cell_ctrl_t          cell_ctrl;
  loc_req_t            loc_req;
  logic [RANK_W-1:0]   lrank;

  logic accept, loc_ok, full, empty, out_load;

  // Batch counters
  logic [RANK_W-1:0]  loaded_q, popped_q, last_rank_q;
  logic [SCORE_W-1:0] last_score_q;
  logic               ovf_q;
  logic [RANK_W-1:0]  popped_inc, grank;

  // Pop in flight
  logic               pend_empty_q;
  dat_t               pend_q;
  logic [RANK_W-1:0]  pend_grank_q;

  // Output register
  logic               out_valid_q;
  logic [ID_W-1:0]    out_reg_id_q;
  logic [RANK_W-1:0]  out_grank_q, out_lrank_q, out_total_q;
  logic [LOCIN_W-1:0] out_loc_q;
  logic               out_empty_q, out_ovf_q;

  assign accept = in_valid_i && !in_stall_o;
  assign loc_ok = (location_i != '0) &&
                  (CMP_W'(location_i) <= CMP_W'(LOCATIONS));
  assign full   = chain[CAPACITY-1].valid;
  assign empty  = !chain[0].valid;

  assign key.valid      = 1'b1;
  assign key.dat.reg_id = reg_id_i;
  assign key.dat.score  = score_i;
  assign key.dat.loc    = LOC_W'(location_i - LOCIN_W'(1));

  // Row of cells: each compares against the key and trades with neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_t left_rec, right_rec;
    logic left_keep;
    if (i == 0) begin : g_head
      assign left_rec  = key;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left_rec  = chain[i-1];
      assign left_keep = keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_rec = '0;
    end else begin : g_inner
      assign right_rec = chain[i+1];
    end
    srms_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .key_i      (key),
      .left_i     (left_rec),
      .left_keep_i(left_keep),
      .right_i    (right_rec),
      .rec_o      (chain[i]),
      .keep_o     (keep[i])
    );
    assign chain_vld[i] = chain[i].valid;
  end

  srms_loc_rank u_loc_rank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (loc_req),
    .score_i(pend_q.score),
    .lrank_o(lrank)
  );

  // Overall competition rank of the head record
  assign popped_inc = sat_inc(popped_q);
  assign grank = ((popped_inc == RANK_W'(1)) || (chain[0].dat.score != last_score_q)) ?
                 popped_inc : last_rank_q;

  // Sequencer: next state, stall, cell and table controls
  always_comb begin
    state_d      = state_q;
    in_stall_o   = 1'b0;
    cell_ctrl    = '0;
    loc_req      = '0;
    loc_req.addr = chain[0].dat.loc;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_INSERT: cell_ctrl.insert = loc_ok && !full;
            ACT_POP: begin
              cell_ctrl.pop = !empty;
              loc_req.rd    = !empty;
              state_d       = ST_POP;
            end
            ACT_CLEAR: begin
              cell_ctrl.clear = 1'b1;
              loc_req.clear   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        in_stall_o     = 1'b1;
        out_load       = !out_valid_q || !out_stall_i;
        loc_req.commit = out_load && !pend_empty_q;
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Batch counters: advance on insert and pop, drop on clear, flag overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q     <= '0;
      popped_q     <= '0;
      last_rank_q  <= '0;
      last_score_q <= '0;
      ovf_q        <= 1'b0;
    end else if (cell_ctrl.clear) begin
      loaded_q     <= '0;
      popped_q     <= '0;
      last_rank_q  <= '0;
      last_score_q <= '0;
      ovf_q        <= 1'b0;
    end else if (cell_ctrl.pop) begin
      popped_q     <= popped_inc;
      last_rank_q  <= grank;
      last_score_q <= chain[0].dat.score;
    end else if (cell_ctrl.insert) begin
      loaded_q <= sat_inc(loaded_q);
    end else if ((state_q == ST_IDLE) && accept && (action_i == ACT_INSERT) &&
                 loc_ok && full) begin
      ovf_q <= 1'b1;
    end
  end

  // Hold the popped record while the table answers
  always_ff @(posedge clk_i) begin
    if (loc_req.rd || ((state_q == ST_IDLE) && accept && (action_i == ACT_POP))) begin
      pend_empty_q <= empty;
      pend_q       <= chain[0].dat;
      pend_grank_q <= grank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (pend_empty_q) begin
        out_reg_id_q <= '0;
        out_grank_q  <= '0;
        out_loc_q    <= '0;
        out_lrank_q  <= '0;
        out_total_q  <= '0;
        out_empty_q  <= 1'b1;
        out_ovf_q    <= 1'b0;
      end else begin
        out_reg_id_q <= pend_q.reg_id;
        out_grank_q  <= pend_grank_q;
        out_loc_q    <= LOCIN_W'(pend_q.loc) + LOCIN_W'(1);
        out_lrank_q  <= lrank;
        out_total_q  <= loaded_q;
        out_empty_q  <= 1'b0;
        out_ovf_q    <= ovf_q;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_reg_id_o   = out_reg_id_q;
  assign overall_rank_o = out_grank_q;
  assign out_location_o = out_loc_q;
  assign loc_rank_o     = out_lrank_q;
  assign total_count_o  = out_total_q;
  assign empty_res_o    = out_empty_q;
  assign overflow_o     = out_ovf_q;

`ifndef SYNTHESIS
  // Occupied cells always form an unbroken run from the head
  a_chain_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot((CAPACITY+1)'(chain_vld) + (CAPACITY+1)'(1)))
    else $error("chain has a hole");

  // The last overall rank never runs ahead of the pop count
  a_rank_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_rank_q <= popped_q)
    else $error("global rank exceeds pop count");

  // An empty pop reports no record data
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |->
      (out_reg_id_q == '0) && (out_grank_q == '0) && (out_lrank_q == '0) &&
      (out_total_q == '0) && !out_ovf_q)
    else $error("empty pop carries data");
`endif

endmodule
`default_nettype wire
